// ===== rtl/utf8_to_latin1_crlf_fold_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the UTF-8 to Latin-1 decoder
// Shorthand for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_LATIN1_CRLF_FOLD_MACROS_SVH
`define UTF8_TO_LATIN1_CRLF_FOLD_MACROS_SVH

// Implication checked only outside reset.
`define U2L_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked at every edge, reset included.
`define U2L_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/u2l_pkg.sv =====
// ---------------------------------------------------------------------------
// u2l_pkg
// Types and constants shared by the UTF-8 to Latin-1 decoder modules.
// ---------------------------------------------------------------------------
package u2l_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out;

    // Results caused by one input byte: one or two output bytes.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } t_grp;

    typedef struct packed {
        logic valid;
        t_grp grp;
    } t_head;

endpackage

// ===== rtl/u2l_front.sv =====
// ---------------------------------------------------------------------------
// u2l_front
// Decodes one byte per cycle while accepted, folds CR/LF and forms the group of results.
// ---------------------------------------------------------------------------
module u2l_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  u2l_pkg::t_in   i_data,
    output logic           o_push,
    output u2l_pkg::t_grp  o_grp
);

    logic [7:0]  r_lead, n_lead;
    logic [20:0] r_part, n_part;
    logic [1:0]  r_seen, n_seen;
    logic        r_cr, n_cr;

    logic        pre_v;
    logic [7:0]  pre_b;
    logic        dec_en;
    logic        dec_v;
    logic [7:0]  dec_b;
    logic        emit;
    logic [20:0] code;
    logic [20:0] new_part;
    logic [2:0]  seen;
    logic [2:0]  need;
    logic [4:0]  mask;
    logic        fq_v;
    logic        fcr_v;
    logic [1:0]  cnt;
    logic [7:0]  b0, b1;
    logic [7:0]  b;

    assign b = i_data.in_byte;

    always_comb begin
        n_lead   = r_lead;
        n_part   = r_part;
        n_seen   = r_seen;
        n_cr     = 1'b0;
        pre_v    = r_cr;
        pre_b    = (b == u2l_pkg::CH_LF) ? u2l_pkg::CH_LF : u2l_pkg::CH_CR;
        dec_en   = !(r_cr && (b == u2l_pkg::CH_LF));
        dec_v    = 1'b0;
        dec_b    = u2l_pkg::CH_QMARK;
        emit     = 1'b0;
        code     = '0;
        mask     = 5'h1F;
        seen     = {1'b0, r_seen} + 3'd1;
        need     = r_lead[5] ? (r_lead[4] ? 3'd4 : 3'd3) : 3'd2;
        new_part = {r_part[14:0], b[5:0]};
        if (dec_en) begin
            if (r_seen == 2'd0) begin
                if (!b[7]) begin
                    code = {13'd0, b};
                    emit = 1'b1;
                end else if (!b[6]) begin
                    dec_v = 1'b1;
                end else begin
                    mask   = b[5] ? (b[4] ? 5'h07 : 5'h0F) : 5'h1F;
                    n_lead = b;
                    n_part = {16'd0, b[4:0] & mask};
                    n_seen = 2'd1;
                end
            end else if (b[7:6] != 2'b10) begin
                dec_v  = 1'b1;
                n_seen = 2'd0;
            end else begin
                n_part = new_part;
                if (r_lead[4] && r_lead[3] && (seen == 3'd3)) begin
                    dec_v  = 1'b1;
                    n_seen = 2'd0;
                end else if (seen >= need) begin
                    n_seen = 2'd0;
                    code   = new_part;
                    emit   = 1'b1;
                end else begin
                    n_seen = seen[1:0];
                end
            end
            if (emit) begin
                if (code > 21'd255) begin
                    dec_v = 1'b1;
                end else if (code[7:0] == u2l_pkg::CH_CR) begin
                    n_cr = 1'b1;
                end else begin
                    dec_v = 1'b1;
                    dec_b = code[7:0];
                end
            end
        end
        fq_v  = i_data.stream_end && (n_seen != 2'd0);
        fcr_v = i_data.stream_end && n_cr;
        if (i_data.stream_end) begin
            n_seen = 2'd0;
            n_cr   = 1'b0;
        end

        cnt = 2'd0;
        b0  = u2l_pkg::CH_QMARK;
        b1  = u2l_pkg::CH_QMARK;
        if (pre_v) begin
            b0  = pre_b;
            cnt = 2'd1;
        end
        if (dec_v) begin
            if (cnt == 2'd0) begin
                b0 = dec_b;
            end else begin
                b1 = dec_b;
            end
            cnt = cnt + 2'd1;
        end
        if (fq_v) begin
            if (cnt == 2'd0) begin
                b0 = u2l_pkg::CH_QMARK;
            end else begin
                b1 = u2l_pkg::CH_QMARK;
            end
            cnt = cnt + 2'd1;
        end
        if (fcr_v) begin
            if (cnt == 2'd0) begin
                b0 = u2l_pkg::CH_CR;
            end else begin
                b1 = u2l_pkg::CH_CR;
            end
            cnt = cnt + 2'd1;
        end
    end

    assign o_push       = i_accept && (cnt != 2'd0);
    assign o_grp.two    = (cnt == 2'd2);
    assign o_grp.first  = b0;
    assign o_grp.second = b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_part <= '0;
            r_seen <= '0;
            r_cr   <= 1'b0;
        end else if (i_accept) begin
            r_lead <= n_lead;
            r_part <= n_part;
            r_seen <= n_seen;
            r_cr   <= n_cr;
        end
    end

endmodule

// ===== rtl/u2l_fifo.sv =====
// ---------------------------------------------------------------------------
// u2l_fifo
// Short queue of result groups between the decoder and the output side.
// ---------------------------------------------------------------------------
module u2l_fifo #(
    parameter int DEPTH = u2l_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u2l_pkg::t_grp  i_grp,
    input  logic           i_deq,
    output logic           o_full,
    output u2l_pkg::t_head o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2l_pkg::t_grp r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full      = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.grp   = r_mem[r_rd];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_deq && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/u2l_back.sv =====
// ---------------------------------------------------------------------------
// u2l_back
// Hands the queued result groups out one byte per transaction.
// ---------------------------------------------------------------------------
module u2l_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  u2l_pkg::t_head i_head,
    input  logic           i_pop,
    output logic           o_deq,
    output logic           o_empty,
    output u2l_pkg::t_out  o_data
);

    logic r_sel;
    logic take;

    assign o_empty         = !i_head.valid;
    assign take            = i_pop && i_head.valid;
    assign o_deq           = take && (!i_head.grp.two || r_sel);
    assign o_data.out_byte = r_sel ? i_head.grp.second : i_head.grp.first;
    assign o_data.run_last = !i_head.grp.two || r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (take) begin
            r_sel <= !o_deq;
        end
    end

endmodule

// ===== rtl/utf8_to_latin1_crlf_fold.sv =====
// Each input byte is taken when push is high and full low, and is decoded in
// the same cycle by a decoder that holds the open sequence and any held CR; it
// yields zero, one or two output bytes, which wait in a queue of FIFO_DEPTH
// groups. The output side delivers one byte per cycle while popped, so a byte
// with two results takes two pops; full rises only when the queue has filled.
// ---------------------------------------------------------------------------
// utf8_to_latin1_crlf_fold
// UTF-8 to Latin-1 byte stream decoder with CR/LF folding.
// ---------------------------------------------------------------------------
module utf8_to_latin1_crlf_fold #(
    parameter int FIFO_DEPTH = u2l_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  u2l_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output u2l_pkg::t_out o_data
);

    logic           accept;
    logic           q_push;
    logic           q_deq;
    u2l_pkg::t_grp  grp;
    u2l_pkg::t_head head;

    assign accept = push && !full;

    u2l_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (q_push),
        .o_grp    (grp)
    );

    u2l_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_grp   (grp),
        .i_deq   (q_deq),
        .o_full  (full),
        .o_head  (head)
    );

    u2l_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_pop   (pop),
        .o_deq   (q_deq),
        .o_empty (empty),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/u2l_checker.sv =====
// ---------------------------------------------------------------------------
// u2l_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "utf8_to_latin1_crlf_fold_macros.svh"

module u2l_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input u2l_pkg::t_out o_data
);

    `U2L_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, empty && !full)
    `U2L_ASSERT_IMPLY(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_data))
    `U2L_ASSERT_IMPLY(a_pair, i_clk, i_rst_n, !empty && pop && !o_data.run_last, !empty)
    `U2L_ASSERT_IMPLY(a_no_source, i_clk, i_rst_n, empty && !(push && !full), empty)

endmodule

bind utf8_to_latin1_crlf_fold u2l_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);
